// File: rtl/sads_pkg.sv
`timescale 1ns / 1ps

package sads_pkg;

    localparam int DEPTH_DEF = 256;
    localparam int COORD_W   = 32;
    localparam int ELEM_W    = 2 * COORD_W;
    localparam int LEN_W     = 9;

    localparam logic [1:0] MODE_PUSH  = 2'd0;
    localparam logic [1:0] MODE_POP   = 2'd1;
    localparam logic [1:0] MODE_PEEK  = 2'd2;
    localparam logic [1:0] MODE_CLEAR = 2'd3;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic SEL_LOWER = 1'b0;
    localparam logic SEL_UPPER = 1'b1;

endpackage

// File: rtl/sads_store.sv
`timescale 1ns / 1ps

module sads_store
    import sads_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [ELEM_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output logic [ELEM_W-1:0] o_rdata
);

    logic [ELEM_W-1:0] r_mem [DEPTH];
    logic [ELEM_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/shared_array_dual_stack_unit.sv
// Two LIFO stacks sharing one synchronous element store.
// The result strobe o_valid rises in the cycle after a transaction is accepted.
// Throughput: 1 transaction per cycle; busy is tied low, as neither the count
// update nor the registered store read port holds off a transaction.
// Reset (i_rst_n low, synchronous): both stack counts cleared, no result pending;
// store contents are not cleared. The receiver cannot stall results.
`timescale 1ns / 1ps

module shared_array_dual_stack_unit
    import sads_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                i_mode,
    input  logic                      i_which_stack,
    input  logic signed [COORD_W-1:0] i_elem_x,
    input  logic signed [COORD_W-1:0] i_elem_y,
    output logic                      o_valid,
    output logic [1:0]                o_status,
    output logic signed [COORD_W-1:0] o_out_x,
    output logic signed [COORD_W-1:0] o_out_y,
    output logic [LEN_W-1:0]          o_stack_length,
    output logic                      o_stack_is_empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]     r_lower, n_lower;
    logic [CW-1:0]     r_upper, n_upper;
    logic              r_valid;
    logic [1:0]        r_status, n_status;
    logic [CW-1:0]     r_len, n_len;
    logic              r_rd, n_rd;

    logic              acc;
    logic [CW-1:0]     cnt_sel;
    logic [CW-1:0]     cnt_dec;
    logic [CW:0]       sum;
    logic              full;
    logic              we, re;
    logic [AW-1:0]     waddr, raddr;
    logic [ELEM_W-1:0] rdata;

    assign busy    = 1'b0;
    assign acc     = start && !busy;
    assign cnt_sel = (i_which_stack == SEL_UPPER) ? r_upper : r_lower;
    assign cnt_dec = cnt_sel - CW'(1);
    assign sum     = {1'b0, r_lower} + {1'b0, r_upper};
    assign full    = sum >= (CW + 1)'(DEPTH);

    // lower top sits at count-1, upper top at DEPTH-count
    assign waddr = (i_which_stack == SEL_UPPER) ?
                   (AW'(DEPTH - 1) - AW'(r_upper)) : AW'(r_lower);
    assign raddr = (i_which_stack == SEL_UPPER) ?
                   (AW'(DEPTH - 1) - AW'(cnt_dec)) : AW'(cnt_dec);

    always_comb begin
        n_lower  = r_lower;
        n_upper  = r_upper;
        n_status = ST_DONE;
        n_len    = cnt_sel;
        n_rd     = 1'b0;
        we       = 1'b0;
        re       = 1'b0;
        unique case (i_mode)
            MODE_PUSH: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    we    = acc;
                    n_len = cnt_sel + CW'(1);
                end
            end
            MODE_POP, MODE_PEEK: begin
                if (cnt_sel == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    re   = acc;
                    n_rd = 1'b1;
                    if (i_mode == MODE_POP) begin
                        n_len = cnt_dec;
                    end
                end
            end
            MODE_CLEAR: begin
                n_len = '0;
            end
        endcase
        if (i_which_stack == SEL_UPPER) begin
            n_upper = n_len;
        end else begin
            n_lower = n_len;
        end
    end

    sads_store #(
        .DEPTH(DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata({i_elem_y, i_elem_x}),
        .i_re   (re),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower <= '0;
            r_upper <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= acc;
            if (acc) begin
                r_lower <= n_lower;
                r_upper <= n_upper;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_status <= n_status;
            r_len    <= n_len;
            r_rd     <= n_rd;
        end
    end

    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_out_x          = r_rd ? rdata[COORD_W-1:0] : '0;
    assign o_out_y          = r_rd ? rdata[ELEM_W-1:COORD_W] : '0;
    assign o_stack_length   = LEN_W'(r_len);
    assign o_stack_is_empty = (r_len == '0);

`ifndef SYNTH
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> o_valid)
        else $error("transaction accepted without a result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !acc |=> !o_valid)
        else $error("result without a transaction");

    a_counts_fit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_lower} + {1'b0, r_upper}) <= (CW + 1)'(DEPTH))
        else $error("stack counts exceed store depth");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_EMPTY) |-> (o_stack_is_empty && !r_rd))
        else $error("empty status with data or nonzero length");
`endif

endmodule
